// ===== rtl/swrb_pkg.sv =====
package swrb_pkg;

    localparam int REF_W  = 17;
    localparam int POS_W  = 32;
    localparam int TAG_W  = 16;
    localparam int DIST_W = 31;

    localparam logic [DIST_W-1:0] MAX_DISTANCE_RESET = 31'd1000;

    // one stored record, 65 bits
    typedef struct packed {
        logic signed [REF_W-1:0] ref_id;
        logic signed [POS_W-1:0] begin_pos;
        logic        [TAG_W-1:0] tag;
    } entry_t;

    typedef enum logic {
        CMP_KEY_LESS,
        CMP_SPAN
    } cmp_op_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FORCE,
        ST_SCAN_RD,
        ST_SCAN_CMP,
        ST_INS_WR,
        ST_BACK_RD,
        ST_BACK_LAT,
        ST_SPAN,
        ST_FLUSH,
        ST_DONE
    } state_t;

endpackage

// ===== rtl/swrb_cmp_unit.sv =====
module swrb_cmp_unit
    import swrb_pkg::*;
(
    input  cmp_op_t           op,
    input  entry_t            a,
    input  entry_t            b,
    input  logic [DIST_W-1:0] max_distance,
    output logic              hit
);

    logic signed [POS_W:0] pos_diff;
    logic signed [POS_W:0] dist_ext;
    logic                  ref_less;
    logic                  ref_eq;

    // one shared subtractor: b.pos - a.pos, exact in 33 bits
    assign pos_diff = {b.begin_pos[POS_W-1], b.begin_pos}
                    - {a.begin_pos[POS_W-1], a.begin_pos};
    assign dist_ext = $signed({{(POS_W+1-DIST_W){1'b0}}, max_distance});
    assign ref_less = a.ref_id < b.ref_id;
    assign ref_eq   = a.ref_id == b.ref_id;

    always_comb
    begin
        case (op)
            CMP_KEY_LESS: hit = ref_less || (ref_eq && (pos_diff > 0));
            CMP_SPAN:     hit = !ref_eq || (pos_diff > dist_ext);
            default:      hit = 1'b0;
        endcase
    end

endmodule

// ===== rtl/swrb_store.sv =====
module swrb_store
    import swrb_pkg::*;
#(
    parameter int DEPTH = 32,
    parameter int AW    = 5
)
(
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  entry_t        wr_data,
    input  logic [AW-1:0] rd_addr,
    output entry_t        rd_data
);

    entry_t mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read
    always_ff @(posedge clk)
    begin
        rd_data <= mem[rd_addr];
    end

endmodule

// ===== rtl/sorted_window_reorder_buffer.sv =====
// sorted reorder buffer over a sliding position window. each insert request
// is placed into a circular store kept in (ref_id, begin_pos) order, equal
// keys in arrival order, by an insertion scan from the back that compares
// and shifts one entry per cycle through a store with one read and one write
// port and one shared compare unit. busy is high for the whole request;
// start is taken only while busy is low. an insert into a full store first
// releases the front entry; a batch end on a store that holds two or more
// entries after the insert then releases front records while the front is
// on another ref_id or more than max_distance before the back entry, and a
// flush releases every record. every result shows on the output ports for
// exactly one cycle with result_valid high; the receiver cannot stall, so it
// must take each one as it comes. last marks the final result of a request;
// a request may give no results. results of a flush come back to back;
// after a batch end release the final result is not back to back with its
// predecessor, and a forced front release is held until the next result of
// the same request or the request's end. the user must write max_distance
// through cfg_wr_en / cfg_wr_data only while the block is idle; the block
// itself does not enforce this.
module sorted_window_reorder_buffer
    import swrb_pkg::*;
#(
    parameter int DEPTH = 32
)
(
    input  logic                    clk,
    input  logic                    rst_n,

    input  logic                    start,
    output logic                    busy,
    input  logic                    kind,
    input  logic signed [REF_W-1:0] ref_id,
    input  logic signed [POS_W-1:0] begin_pos,
    input  logic        [TAG_W-1:0] tag,
    input  logic                    batch_end,

    input  logic                    cfg_wr_en,
    input  logic       [DIST_W-1:0] cfg_wr_data,

    output logic                    result_valid,
    output logic signed [REF_W-1:0] out_ref_id,
    output logic signed [POS_W-1:0] out_begin_pos,
    output logic        [TAG_W-1:0] out_tag,
    output logic                    last
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    // circular position: base plus offset, both below depth
    function automatic logic [AW-1:0] wrap_addr(input logic [AW-1:0] base,
                                                input logic [AW-1:0] off);
        logic [AW:0] sum;
        sum = {1'b0, base} + {1'b0, off};
        if (sum >= (AW+1)'(DEPTH))
        begin
            sum = sum - (AW+1)'(DEPTH);
        end
        return sum[AW-1:0];
    endfunction

    state_t            state_reg, state_next;
    logic [AW-1:0]     head_reg, head_next;
    logic [CW-1:0]     fill_reg, fill_next;
    logic [AW-1:0]     scan_reg, scan_next;
    entry_t            item_reg;
    logic              batch_end_reg;
    entry_t            back_reg;
    logic [DIST_W-1:0] max_distance_reg;

    // one result held back until we know whether it is the final one
    logic              pend_valid_reg;
    entry_t            pend_reg;

    logic              result_valid_reg;
    entry_t            out_reg;
    logic              last_reg;

    // store ports
    logic              wr_en;
    logic [AW-1:0]     wr_off;
    entry_t            wr_data;
    logic [AW-1:0]     rd_off;
    entry_t            rd_data;

    // shared compare unit
    cmp_op_t           cmp_op;
    entry_t            cmp_a;
    entry_t            cmp_b;
    logic              cmp_hit;

    // sequencer controls
    logic              accept;
    logic              produce;
    logic              pop;
    logic              grow;
    logic              full;
    logic              post_release;

    assign accept       = start && (state_reg == ST_IDLE);
    assign busy         = state_reg != ST_IDLE;
    assign full         = fill_reg == CW'(DEPTH);
    // after an insert, a batch end with two or more entries checks the window
    assign post_release = batch_end_reg && (fill_reg != '0);

    swrb_store #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wrap_addr(head_reg, wr_off)),
        .wr_data (wr_data),
        .rd_addr (wrap_addr(head_reg, rd_off)),
        .rd_data (rd_data)
    );

    swrb_cmp_unit u_cmp (
        .op           (cmp_op),
        .a            (cmp_a),
        .b            (cmp_b),
        .max_distance (max_distance_reg),
        .hit          (cmp_hit)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    if (kind)
                    begin
                        state_next = (fill_reg == '0) ? ST_DONE : ST_FLUSH;
                    end
                    else if (full)
                    begin
                        state_next = ST_FORCE;
                    end
                    else if (fill_reg == '0)
                    begin
                        state_next = ST_INS_WR;
                    end
                    else
                    begin
                        state_next = ST_SCAN_RD;
                    end
                end
            end
            ST_FORCE:    state_next = ST_SCAN_RD;
            ST_SCAN_RD:  state_next = ST_SCAN_CMP;
            ST_SCAN_CMP:
            begin
                if (cmp_hit)
                begin
                    if (scan_reg == '0)
                    begin
                        state_next = ST_INS_WR;
                    end
                end
                else
                begin
                    state_next = post_release ? ST_BACK_RD : ST_DONE;
                end
            end
            ST_INS_WR:   state_next = post_release ? ST_BACK_RD : ST_DONE;
            ST_BACK_RD:  state_next = ST_BACK_LAT;
            ST_BACK_LAT: state_next = ST_SPAN;
            ST_SPAN:
            begin
                if (!cmp_hit)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_FLUSH:
            begin
                if (fill_reg == CW'(1))
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:     state_next = ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
    end

    // datapath controls
    always_comb
    begin
        rd_off    = '0;
        wr_en     = 1'b0;
        wr_off    = '0;
        wr_data   = item_reg;
        cmp_op    = CMP_KEY_LESS;
        cmp_a     = item_reg;
        cmp_b     = rd_data;
        produce   = 1'b0;
        pop       = 1'b0;
        grow      = 1'b0;
        scan_next = scan_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                // front is read ahead for flush and forced release
                if (start && !kind && !full && (fill_reg != '0))
                begin
                    scan_next = AW'(fill_reg - CW'(1));
                end
            end
            ST_FORCE:
            begin
                produce   = 1'b1;
                pop       = 1'b1;
                scan_next = AW'(DEPTH - 2);
            end
            ST_SCAN_RD:
            begin
                rd_off = scan_reg;
            end
            ST_SCAN_CMP:
            begin
                // read the next lower entry while this one is compared
                rd_off = (scan_reg == '0) ? '0 : scan_reg - AW'(1);
                wr_en  = 1'b1;
                wr_off = scan_reg + AW'(1);
                if (cmp_hit)
                begin
                    wr_data = rd_data;
                    if (scan_reg != '0)
                    begin
                        scan_next = scan_reg - AW'(1);
                    end
                end
                else
                begin
                    grow = 1'b1;
                end
            end
            ST_INS_WR:
            begin
                wr_en = 1'b1;
                grow  = 1'b1;
            end
            ST_BACK_RD:
            begin
                rd_off = AW'(fill_reg - CW'(1));
            end
            ST_BACK_LAT:
            begin
                rd_off = '0;
            end
            ST_SPAN:
            begin
                cmp_op = CMP_SPAN;
                cmp_a  = rd_data;
                cmp_b  = back_reg;
                rd_off = AW'(1);
                if (cmp_hit)
                begin
                    produce = 1'b1;
                    pop     = 1'b1;
                end
            end
            ST_FLUSH:
            begin
                rd_off  = AW'(1);
                produce = 1'b1;
                pop     = 1'b1;
            end
            ST_DONE:
            begin
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        head_next = head_reg;
        fill_next = fill_reg;
        if (pop)
        begin
            head_next = wrap_addr(head_reg, AW'(1));
            fill_next = fill_reg - CW'(1);
        end
        else if (grow)
        begin
            fill_next = fill_reg + CW'(1);
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            head_reg         <= '0;
            fill_reg         <= '0;
            pend_valid_reg   <= 1'b0;
            result_valid_reg <= 1'b0;
            max_distance_reg <= MAX_DISTANCE_RESET;
        end
        else
        begin
            state_reg        <= state_next;
            head_reg         <= head_next;
            fill_reg         <= fill_next;
            result_valid_reg <= (produce && pend_valid_reg)
                             || ((state_reg == ST_DONE) && pend_valid_reg);
            if (produce)
            begin
                pend_valid_reg <= 1'b1;
            end
            else if (state_reg == ST_DONE)
            begin
                pend_valid_reg <= 1'b0;
            end
            if (cfg_wr_en)
            begin
                max_distance_reg <= cfg_wr_data;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        scan_reg <= scan_next;
        if (accept)
        begin
            item_reg      <= '{ref_id: ref_id, begin_pos: begin_pos, tag: tag};
            batch_end_reg <= batch_end;
        end
        if (state_reg == ST_BACK_LAT)
        begin
            back_reg <= rd_data;
        end
        if (produce)
        begin
            pend_reg <= rd_data;
        end
        // older held result goes out when a newer one arrives, or at the end
        if (produce || (state_reg == ST_DONE))
        begin
            out_reg  <= pend_reg;
            last_reg <= !produce;
        end
    end

    assign result_valid  = result_valid_reg;
    assign out_ref_id    = out_reg.ref_id;
    assign out_begin_pos = out_reg.begin_pos;
    assign out_tag       = out_reg.tag;
    assign last          = last_reg;

    // an accepted request keeps the block busy in the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("request accepted but block not busy");

    // fill never goes beyond the store depth
    assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= CW'(DEPTH))
        else $error("fill count beyond depth");

    // no held result is left over once the block is idle
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_IDLE |-> !pend_valid_reg)
        else $error("held result left at idle");

    // the final result of a request is not followed by another one at once
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && last |=> !result_valid)
        else $error("result right after final result");

    // releases only happen from a non-empty store
    assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> fill_reg != '0)
        else $error("release from empty store");

endmodule
